/* sv/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b in the same cycle
`define CHK_IMPLY(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("check failed");
// a implies b in the next cycle
`define CHK_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("check failed");
`endif

/* sv/dst_pkg.sv */
//------------------------------------------------------------------------------
// dst_pkg
// shared types and constants of the stable time step block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package dst_pkg;
	localparam int MAX_COMPONENTS = 4;
	localparam logic [2:0] CFG_DIMS = 3'd0;
	localparam logic [2:0] CFG_UNIF = 3'd1;
	localparam logic [2:0] CFG_UDIFF = 3'd2;
	localparam logic [2:0] CFG_COUNT = 3'd3;
	localparam logic [2:0] CFG_DENS = 3'd4;

	// datapath operation selector
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_LOAD = 3'd1;
	localparam logic [2:0] OP_SQ = 3'd2;
	localparam logic [2:0] OP_INV = 3'd3;
	localparam logic [2:0] OP_MUL = 3'd4;
	localparam logic [2:0] OP_DENS = 3'd5;
	localparam logic [2:0] OP_STEP = 3'd6;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] sel;   // size index for square / inverse
		logic       start; // start divider
	} dst_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} dst_stat_t;
endpackage

/* sv/diffusion_stable_timestep.sv */
//------------------------------------------------------------------------------
// diffusion_stable_timestep
// stable explicit diffusion time step over a stream of mesh elements
//------------------------------------------------------------------------------
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes registers;
//    cfg_ready is always high; the user must write them only while the block
//    is idle, which the block does not enforce; reset sets them to defaults
//  - in channel takes one element per request; in_ready is high only when the
//    sequencer is idle, so one element is processed at a time
//  - each element, once accepted in the idle state, takes for x and y (and z
//    with three dimensions) a square, a divider start, the divider steps and
//    done, then the product, a divider pass in density mode, and the maximum
//  - a request marked last_element adds one more divider pass (none when the
//    maximum is zero), then the result (stable_step, no_diffusion) sits in an
//    output register; the next element is accepted while the result waits
//  - if the receiver stalls, a further last element waits before loading its
//    own result; reset also clears the maximum and the output valid
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module diffusion_stable_timestep (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] size_x,
	input  logic [31:0] size_y,
	input  logic [31:0] size_z,
	input  logic [31:0] diff_comp_0,
	input  logic [31:0] diff_comp_1,
	input  logic [31:0] diff_comp_2,
	input  logic [31:0] diff_comp_3,
	input  logic [31:0] density,
	input  logic        last_element,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] stable_step,
	output logic        no_diffusion
);
	import dst_pkg::*;

	logic [1:0]  dims_q;
	logic        unif_q, dens_q;
	logic [31:0] udiff_q;
	logic [2:0]  count_q;
	logic        ov_q;
	logic [31:0] step_q;
	logic        nd_q;
	dst_cmd_t    cmd;
	dst_stat_t   stat;
	logic [31:0] step_val;
	logic        step_zero, res_load, res_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= 2'd3;
			unif_q  <= 1'b0;
			udiff_q <= '0;
			count_q <= 3'd1;
			dens_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIMS:  dims_q  <= cfg_data[1:0];
				CFG_UNIF:  unif_q  <= cfg_data[0];
				CFG_UDIFF: udiff_q <= cfg_data;
				CFG_COUNT: count_q <= cfg_data[2:0];
				CFG_DENS:  dens_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign res_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (res_load) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			step_q <= step_val;
			nd_q   <= step_zero;
		end
	end

	assign out_valid    = ov_q;
	assign stable_step  = step_q;
	assign no_diffusion = nd_q;

	dst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.last_element(last_element), .space_dimensions(dims_q), .density_mode(dens_q),
		.cmd(cmd), .stat(stat), .step_zero(step_zero), .res_load(res_load),
		.res_free(res_free)
	);

	dst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.space_dimensions(dims_q), .uniform_mode(unif_q), .uniform_diffusivity(udiff_q),
		.component_count(count_q), .density_mode(dens_q),
		.size_x(size_x), .size_y(size_y), .size_z(size_z),
		.diff_comp_0(diff_comp_0), .diff_comp_1(diff_comp_1),
		.diff_comp_2(diff_comp_2), .diff_comp_3(diff_comp_3), .density(density),
		.step_val(step_val), .step_zero(step_zero)
	);
endmodule

/* sv/dst_div.sv */
//------------------------------------------------------------------------------
// dst_div
// restoring 128 by 64 divider, one quotient bit per cycle, 64-bit saturation
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dst_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         busy,
	output logic         done,
	output logic [63:0]  quot
);
	logic [127:0] num_q;
	logic [63:0]  den_q, rem_q, q_q;
	logic [6:0]   cnt_q;
	logic         over_q, zero_q, busy_q, done_q;
	logic [64:0]  rsh;
	logic         ge;

	assign rsh = {rem_q, num_q[127]};
	assign ge  = rsh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
			zero_q <= (den == 64'd0);
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			if (q_q[63]) over_q <= 1'b1;
			if (ge) begin
				rem_q <= 64'(rsh - {1'b0, den_q});
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= rsh[63:0];
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = (over_q || zero_q) ? '1 : q_q;
endmodule

/* sv/dst_datapath.sv */
//------------------------------------------------------------------------------
// dst_datapath
// element registers, squarer, shared divider, multiplier and running maximum
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dst_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  dst_pkg::dst_cmd_t cmd,
	output dst_pkg::dst_stat_t stat,
	input  logic [1:0]        space_dimensions,
	input  logic              uniform_mode,
	input  logic [31:0]       uniform_diffusivity,
	input  logic [2:0]        component_count,
	input  logic              density_mode,
	input  logic [31:0]       size_x,
	input  logic [31:0]       size_y,
	input  logic [31:0]       size_z,
	input  logic [31:0]       diff_comp_0,
	input  logic [31:0]       diff_comp_1,
	input  logic [31:0]       diff_comp_2,
	input  logic [31:0]       diff_comp_3,
	input  logic [31:0]       density,
	output logic [31:0]       step_val,
	output logic              step_zero
);
	import dst_pkg::*;

	logic [31:0] sz_q [3];
	logic [31:0] alpha_q, dens_q;
	logic [63:0] sq_q, sum_q, coef_q, max_q, ph_q, pl_q;
	logic [1:0]  mphase_q;
	logic [31:0] a01, a23, amax;
	logic [2:0]  n;
	logic [127:0] dnum;
	logic [63:0]  dden, quot;
	logic [64:0]  s65, m65;
	logic         dbusy, ddone;

	always_comb begin
		n = component_count;
		if (n == 3'd0) n = 3'd1;
		if (n > 3'(MAX_COMPONENTS)) n = 3'(MAX_COMPONENTS);
		a01 = (n >= 3'd2 && diff_comp_1 > diff_comp_0) ? diff_comp_1 : diff_comp_0;
		a23 = (n >= 3'd4 && diff_comp_3 > diff_comp_2) ? diff_comp_3 : diff_comp_2;
		amax = (n >= 3'd3 && a23 > a01) ? a23 : a01;
	end

	always_comb begin
		dnum = {64'd0, 64'h0000_8000_0000_0000};
		dden = max_q;
		case (cmd.op)
			OP_INV: begin
				dnum = {64'd256, 64'd0};
				dden = sq_q;
			end
			OP_DENS: begin
				dnum = {48'd0, coef_q, 16'd0};
				dden = {32'd0, dens_q};
			end
			default: ;
		endcase
	end

	dst_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quot(quot)
	);

	assign s65 = {1'b0, sum_q} + {1'b0, quot};
	assign m65 = {1'b0, ph_q[55:0], 8'd0} + {1'b0, 24'd0, pl_q[63:24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= '0;
			mphase_q <= '0;
		end else begin
			case (cmd.op)
				OP_STEP: max_q <= '0;
				OP_MUL: mphase_q <= mphase_q + 2'd1;
				default: mphase_q <= '0;
			endcase
			if (cmd.op == OP_LOAD && cmd.sel == 2'd1 && coef_q > max_q) max_q <= coef_q;
		end
	end

	// sel 0 on load captures the element, sel 1 folds coef into the maximum
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: if (cmd.sel == 2'd0) begin
				sz_q[0] <= size_x;
				sz_q[1] <= size_y;
				sz_q[2] <= size_z;
				alpha_q <= uniform_mode ? uniform_diffusivity : amax;
				dens_q  <= density;
				sum_q   <= '0;
			end
			OP_SQ: sq_q <= {32'd0, sz_q[cmd.sel]} * {32'd0, sz_q[cmd.sel]};
			OP_INV: if (ddone) sum_q <= s65[64] ? '1 : s65[63:0];
			OP_MUL: begin
				if (mphase_q == 2'd0) begin
					ph_q <= {32'd0, sum_q[63:32]} * {32'd0, alpha_q};
					pl_q <= {32'd0, sum_q[31:0]} * {32'd0, alpha_q};
				end else begin
					coef_q <= (ph_q[63:56] != 8'd0 || m65[64]) ? '1 : m65[63:0];
				end
			end
			OP_DENS: if (ddone) coef_q <= quot;
			default: ;
		endcase
	end

	assign stat.div_busy = dbusy;
	assign stat.div_done = ddone;
	assign step_zero = (max_q == 64'd0);
	assign step_val  = step_zero ? '1 : ((quot[63:32] != 32'd0) ? '1 : quot[31:0]);

	logic unused;
	assign unused = ^{space_dimensions, density_mode};
endmodule

/* sv/dst_ctrl.sv */
//------------------------------------------------------------------------------
// dst_ctrl
// sequencer for one element: squares, inverses, product, density, maximum, result
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               last_element,
	input  logic [1:0]         space_dimensions,
	input  logic               density_mode,
	output dst_pkg::dst_cmd_t  cmd,
	input  dst_pkg::dst_stat_t stat,
	input  logic               step_zero,
	output logic               res_load,
	input  logic               res_free
);
	import dst_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_INVS = 4'd2, S_INVW = 4'd3,
		S_MUL0 = 4'd4, S_MUL1 = 4'd5, S_DENS = 4'd6, S_DENW = 4'd7, S_FOLD = 4'd8,
		S_STS = 4'd9, S_STW = 4'd10, S_OUT = 4'd11;

	logic [3:0] st_q;
	logic [1:0] dim_q;
	logic       last_q;
	logic [1:0] nd;

	assign nd = (space_dimensions == 2'd3) ? 2'd2 : 2'd1;
	assign in_ready = (st_q == S_IDLE);

	always_comb begin
		cmd = '{op: OP_NONE, sel: dim_q, start: 1'b0};
		res_load = 1'b0;
		case (st_q)
			S_IDLE: if (in_valid) cmd = '{op: OP_LOAD, sel: 2'd0, start: 1'b0};
			S_SQ:   cmd.op = OP_SQ;
			S_INVS: begin cmd.op = OP_INV; cmd.start = 1'b1; end
			S_INVW: cmd.op = OP_INV;
			S_MUL0, S_MUL1: cmd.op = OP_MUL;
			S_DENS: begin cmd.op = OP_DENS; cmd.start = 1'b1; end
			S_DENW: cmd.op = OP_DENS;
			S_FOLD: cmd = '{op: OP_LOAD, sel: 2'd1, start: 1'b0};
			S_STS:  cmd.start = !step_zero;
			S_OUT:  if (res_free) begin
				cmd.op = OP_STEP;
				res_load = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			dim_q  <= '0;
			last_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid) begin
					st_q   <= S_SQ;
					dim_q  <= '0;
					last_q <= last_element;
				end
				S_SQ:   st_q <= S_INVS;
				S_INVS: st_q <= S_INVW;
				S_INVW: if (stat.div_done) begin
					if (dim_q == nd) st_q <= S_MUL0;
					else begin
						dim_q <= dim_q + 2'd1;
						st_q  <= S_SQ;
					end
				end
				S_MUL0: st_q <= S_MUL1;
				S_MUL1: st_q <= density_mode ? S_DENS : S_FOLD;
				S_DENS: st_q <= S_DENW;
				S_DENW: if (stat.div_done) st_q <= S_FOLD;
				S_FOLD: st_q <= last_q ? S_STS : S_IDLE;
				S_STS:  st_q <= step_zero ? S_OUT : S_STW;
				S_STW:  if (stat.div_done) st_q <= S_OUT;
				S_OUT:  if (res_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic unused;
	assign unused = stat.div_busy;
endmodule

/* sv/dst_checker.sv */
//------------------------------------------------------------------------------
// dst_checker
// port level checks of the stable time step block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] stable_step,
	input logic        no_diffusion
);
	// in_ready drops once an element is accepted
	`CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// zero maximum always shows the saturated step
	`CHK_IMPLY(a_zero_sat, out_valid && no_diffusion, stable_step == 32'hFFFF_FFFF)
	// a stalled result holds
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(stable_step))
	// no result appears right after acceptance
	`CHK_NEXT(a_no_early_out, in_valid && in_ready && !out_valid, !out_valid)
endmodule

bind diffusion_stable_timestep dst_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .stable_step(stable_step),
	.no_diffusion(no_diffusion)
);

/* test/tb.sv */
//------------------------------------------------------------------------------
// tb
// checks the stable time step block: directed element requests and requests with
// random sizes, diffusivities and densities across register settings, results
// predicted in fixed point and compared field by field with the output stream
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import dst_pkg::*;

	typedef struct packed {
		logic [31:0] sx, sy, sz, d0, d1, d2, d3, dens;
		logic        last;
	} element_t;

	typedef struct packed {
		logic [31:0] step;
		logic        nodiff;
	} step_res_t;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_ready;
	logic [31:0] size_x, size_y, size_z;
	logic [31:0] diff_comp_0, diff_comp_1, diff_comp_2, diff_comp_3, density;
	logic        last_element;
	logic        out_valid, out_ready;
	logic [31:0] stable_step;
	logic        no_diffusion;

	diffusion_stable_timestep dut (.*);

	// predictor state
	logic [1:0]  p_dims;
	logic        p_unif;
	logic [31:0] p_udiff;
	logic [2:0]  p_count;
	logic        p_dens;
	logic [63:0] p_max;

	element_t  pending_q[$];
	step_res_t step_q[$];
	int        errors, n_elems, n_steps;
	bit        quiet;
	int        in_gap, out_gap;

	function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
		logic [127:0] q;
		if (den == 0) return '1;
		q = num / den;
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = a + b;
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] inv_sq(logic [31:0] h);
		logic [63:0] sq;
		sq = h * h;
		return div_sat(128'd1 << 72, sq);
	endfunction

	task automatic predict_step(element_t e);
		logic [63:0] sum, coef, ph, pl;
		logic [31:0] alpha;
		int n;
		sum = add_sat(inv_sq(e.sx), inv_sq(e.sy));
		if (p_dims == 2'd3) sum = add_sat(sum, inv_sq(e.sz));
		if (p_unif) alpha = p_udiff;
		else begin
			n = p_count;
			if (n < 1) n = 1;
			if (n > MAX_COMPONENTS) n = MAX_COMPONENTS;
			alpha = e.d0;
			if (n > 1 && e.d1 > alpha) alpha = e.d1;
			if (n > 2 && e.d2 > alpha) alpha = e.d2;
			if (n > 3 && e.d3 > alpha) alpha = e.d3;
		end
		ph = sum[63:32] * alpha;
		pl = sum[31:0] * alpha;
		coef = (ph[63:56] != 0) ? '1 : add_sat(ph << 8, pl >> 24);
		if (p_dens) coef = div_sat({64'd0, coef} << 16, {32'd0, e.dens});
		if (coef > p_max) p_max = coef;
		if (e.last) begin
			if (p_max == 0) step_q.push_back('{32'hFFFF_FFFF, 1'b1});
			else begin
				ph = div_sat(128'd1 << 47, p_max);
				step_q.push_back('{(ph > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ph[31:0], 1'b0});
			end
			p_max = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// element driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
			{size_x, size_y, size_z, diff_comp_0, diff_comp_1, diff_comp_2,
				diff_comp_3, density, last_element} <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_step({size_x, size_y, size_z, diff_comp_0, diff_comp_1,
					diff_comp_2, diff_comp_3, density, last_element});
				n_elems++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					in_gap <= $urandom_range(0, 6);
					in_valid <= 0;
				end else if (pending_q.size() > 0) begin
					element_t e;
					e = pending_q.pop_front();
					{size_x, size_y, size_z, diff_comp_0, diff_comp_1, diff_comp_2,
						diff_comp_3, density, last_element} <= e;
					in_valid <= 1;
				end else in_valid <= 0;
			end
		end
	end

	// result monitor with receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				n_steps++;
				if (step_q.size() == 0) begin
					$display("%0t: unexpected result step=%h nodiff=%b", $time,
						stable_step, no_diffusion);
					errors++;
				end else begin
					step_res_t x;
					x = step_q.pop_front();
					if (x.step !== stable_step) begin
						$display("%0t: stable_step expected %h actual %h", $time,
							x.step, stable_step);
						errors++;
					end
					if (x.nodiff !== no_diffusion) begin
						$display("%0t: no_diffusion expected %b actual %b", $time,
							x.nodiff, no_diffusion);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(0, 6);
				out_ready <= 0;
			end else out_ready <= 1;
		end
	end

	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
			default: return $urandom_range(32'h0004_0000, 32'h0800_0000);
		endcase
	endfunction

	function automatic element_t rand_elem(bit last);
		element_t e;
		e.sx = rand_size();
		e.sy = rand_size();
		e.sz = rand_size();
		e.d0 = $urandom; e.d1 = $urandom; e.d2 = $urandom; e.d3 = $urandom;
		if ($urandom_range(0, 3) == 0) e.d0 = $urandom_range(0, 32'h0100_0000);
		e.dens = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 32'h0004_0000);
		if ($urandom_range(0, 40) == 0) e.dens = 0;
		e.last = last;
		return e;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_DIMS:  p_dims = val[1:0];
			CFG_UNIF:  p_unif = val[0];
			CFG_UDIFF: p_udiff = val;
			CFG_COUNT: p_count = val[2:0];
			CFG_DENS:  p_dens = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || step_q.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic push(element_t e);
		pending_q.push_back(e);
	endtask

	initial begin
		element_t e;
		int phase, k, len;
		errors = 0; n_elems = 0; n_steps = 0; quiet = 0;
		p_dims = 3; p_unif = 0; p_udiff = 0; p_count = 1; p_dens = 0; p_max = 0;
		cfg_valid = 0; cfg_index = CFG_DIMS; cfg_data = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, extremes, zero maximum, zero size
		push('{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
			0, 0, 0, 32'h0001_0000, 1});
		push('{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, '1, '1, '1, 1, 1});
		push('{0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 1, 1});
		push('{'1, '1, '1, '1, '1, '1, '1, '1, 0});
		push('{1, 1, 1, 1, 1, 1, 1, '1, 1});
		push('{'1, '1, '1, 1, 0, 0, 0, 1, 1});
		drain();
		write_reg(CFG_COUNT, 0);
		write_reg(CFG_DIMS, 0);
		push('{32'h0100_0000, 32'h0080_0000, 32'h0, 32'h0100_0000, '1, 0, 0, 1, 1});
		drain();
		write_reg(CFG_COUNT, 7);
		write_reg(CFG_DENS, 1);
		write_reg(CFG_DIMS, 1);
		push('{32'h0100_0000, 32'h0100_0000, 0, 1, 2, 3, '1, 0, 1});
		push('{32'h0100_0000, 32'h0200_0000, 0, 1, 2, 3, '1, 32'h0001_0000, 1});
		push('{32'h0100_0000, 32'h0200_0000, 0, 0, 0, 0, 0, '1, 1});
		drain();
		write_reg(CFG_UNIF, 1);
		write_reg(CFG_UDIFF, '1);
		write_reg(CFG_DIMS, 2);
		push('{32'h0010_0000, 32'h0010_0000, 0, 0, 0, 0, 0, 1, 1});
		push('{'1, '1, '1, 0, 0, 0, 0, '1, 1});
		drain();

		// random phases over register settings, the last one without stalls
		for (phase = 0; phase < 10; phase++) begin
			if (phase == 9) quiet = 1;
			write_reg(CFG_DIMS, $urandom_range(0, 3));
			write_reg(CFG_UNIF, $urandom_range(0, 2) == 0);
			write_reg(CFG_UDIFF, (phase % 3 == 0) ? 32'd0 : $urandom);
			write_reg(CFG_COUNT, (phase < 5) ? phase + 1 : $urandom_range(0, 7));
			write_reg(CFG_DENS, phase[0]);
			for (k = 0; k < 55; k++) begin
				len = $urandom_range(1, 6);
				e = rand_elem(k == 54 || $urandom_range(0, len) == 0);
				push(e);
			end
			drain();
		end
		$display("covered %0d elements and %0d step results over several register settings",
			n_elems, n_steps);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#300ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
